// ----- design/convex_hull_graham_scan_defines.svh -----
// Assertion macros shared by the convex hull controller and datapath.
`ifndef CONVEX_HULL_GRAHAM_SCAN_DEFINES_SVH
`define CONVEX_HULL_GRAHAM_SCAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/chgs_pkg.sv -----
// Types and constants shared by the convex hull modules.
package chgs_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int WIDE_W  = 35;
    localparam int XY_W    = 2 * COORD_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      end_of_set;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] hull_x;
        logic signed [COORD_W-1:0] hull_y;
        logic                      final_vertex;
        logic                      points_dropped;
    } t_hull_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_xy;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_run;
        logic piv_init;
        logic piv_cmp;
        logic sort_init;
        logic q_latch;
        logic srt_rd_j;
        logic geo_sort;
        logic sort_shift;
        logic sort_ins;
        logic next_i;
        logic scan_init0;
        logic scan_init1;
        logic geo_scan_new;
        logic geo_scan;
        logic pop;
        logic pop_fill;
        logic push;
        logic out_init;
        logic out_emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic i_last;
        logic q_is_p;
        logic j_gt1;
        logic sort_first;
        logic cpos;
        logic top_gt1;
        logic i_eq_k;
        logic k_eq1;
        logic e_last;
    } t_stat;

endpackage

// ----- design/chgs_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module chgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/chgs_dp.sv -----
// Datapath of the convex hull block: point stores, counters and turn test pipeline.
module chgs_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  chgs_pkg::t_point_in i_point,
    input  chgs_pkg::t_cmd      i_cmd,
    output chgs_pkg::t_stat     o_stat,
    output chgs_pkg::t_hull_out o_result,
    output logic                o_valid
);

`include "convex_hull_graham_scan_defines.svh"

    localparam int CW   = $clog2(MAX_POINTS + 2);
    localparam int SAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int LDEP = MAX_POINTS + 1;
    localparam int LAW  = $clog2(LDEP);

    logic [CW-1:0] r_n, r_i, r_j, r_k, r_top, r_e;
    logic          r_ovf;
    chgs_pkg::t_xy r_p, r_q, r_s, r_c, r_t0, r_t1;
    chgs_pkg::t_xy r_ga, r_gb, r_gc;
    logic signed [chgs_pkg::DIFF_W-1:0] r_ux, r_uy, r_vx, r_vy;
    logic signed [chgs_pkg::PROD_W-1:0] r_m1, r_m2, r_sa1, r_sa2, r_sb1, r_sb2;
    logic signed [chgs_pkg::WIDE_W-1:0] r_cross, r_da, r_db;
    chgs_pkg::t_hull_out r_res;
    logic                r_vld;

    // Memory ports.
    logic                        st_we;
    logic [SAW-1:0]              st_waddr, st_raddr;
    logic [chgs_pkg::XY_W-1:0]   st_wdata, st_rdata;
    logic                        sr_we;
    logic [LAW-1:0]              sr_waddr, sr_raddr;
    logic [chgs_pkg::XY_W-1:0]   sr_wdata, sr_rdata;
    logic                        sk_we;
    logic [LAW-1:0]              sk_waddr, sk_raddr;
    logic [chgs_pkg::XY_W-1:0]   sk_wdata, sk_rdata;
    chgs_pkg::t_xy               st_rd, sr_rd, sk_rd, in_xy;
    logic                        st_room, piv_better;
    logic [CW-1:0]               jm1, topm2, topp1;

    assign st_rd = chgs_pkg::t_xy'(st_rdata);
    assign sr_rd = chgs_pkg::t_xy'(sr_rdata);
    assign sk_rd = chgs_pkg::t_xy'(sk_rdata);
    assign in_xy.x = i_point.point_x;
    assign in_xy.y = i_point.point_y;
    assign st_room = (r_n < CW'(MAX_POINTS));
    assign jm1   = r_j - CW'(1);
    assign topm2 = r_top - CW'(2);
    assign topp1 = r_top + CW'(1);

    assign piv_better = (st_rd.y < r_p.y) || ((st_rd.y == r_p.y) && (st_rd.x > r_p.x));

    // Point store.
    assign st_we    = i_cmd.load && st_room;
    assign st_waddr = r_n[SAW-1:0];
    assign st_wdata = in_xy;
    assign st_raddr = r_i[SAW-1:0];

    // Sorted list.
    always_comb begin
        sr_we    = i_cmd.sort_init || i_cmd.sort_shift || i_cmd.sort_ins || i_cmd.scan_init0;
        sr_waddr = r_j[LAW-1:0];
        sr_wdata = r_q;
        if (i_cmd.sort_init) begin
            sr_waddr = '0;
            sr_wdata = r_p;
        end else if (i_cmd.scan_init0) begin
            sr_waddr = r_k[LAW-1:0];
            sr_wdata = r_p;
        end else if (i_cmd.sort_shift) begin
            sr_wdata = r_s;
        end
        sr_raddr = r_i[LAW-1:0];
        if (i_cmd.srt_rd_j) begin
            sr_raddr = jm1[LAW-1:0];
        end else if (i_cmd.scan_init0) begin
            sr_raddr = LAW'(1);
        end
    end

    // Hull stack.
    always_comb begin
        sk_we    = i_cmd.scan_init0 || i_cmd.scan_init1 || i_cmd.push;
        sk_waddr = topp1[LAW-1:0];
        sk_wdata = r_c;
        if (i_cmd.scan_init0) begin
            sk_waddr = '0;
            sk_wdata = r_p;
        end else if (i_cmd.scan_init1) begin
            sk_waddr = LAW'(1);
            sk_wdata = sr_rd;
        end
        sk_raddr = i_cmd.pop ? topm2[LAW-1:0] : r_e[LAW-1:0];
    end

    chgs_ram #(.WIDTH(chgs_pkg::XY_W), .DEPTH(MAX_POINTS)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    chgs_ram #(.WIDTH(chgs_pkg::XY_W), .DEPTH(LDEP)) u_sorted (
        .i_clk(i_clk), .i_we(sr_we), .i_waddr(sr_waddr), .i_wdata(sr_wdata),
        .i_raddr(sr_raddr), .o_rdata(sr_rdata)
    );

    chgs_ram #(.WIDTH(chgs_pkg::XY_W), .DEPTH(LDEP)) u_stack (
        .i_clk(i_clk), .i_we(sk_we), .i_waddr(sk_waddr), .i_wdata(sk_wdata),
        .i_raddr(sk_raddr), .o_rdata(sk_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_ovf <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (st_room) begin
                    r_n <= r_n + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.clr_run) begin
                r_n   <= '0;
                r_ovf <= 1'b0;
            end
            r_vld <= i_cmd.out_emit;
        end
    end

    // Counters and point registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.piv_init || i_cmd.sort_init) begin
            r_i <= '0;
        end else if (i_cmd.scan_init0) begin
            r_i <= CW'(2);
        end else if (i_cmd.piv_cmp || i_cmd.next_i || i_cmd.sort_ins || i_cmd.push) begin
            r_i <= r_i + CW'(1);
        end

        if (i_cmd.piv_cmp && ((r_i == '0) || piv_better)) begin
            r_p <= st_rd;
        end

        if (i_cmd.q_latch) begin
            r_q <= st_rd;
            r_j <= r_k;
        end else if (i_cmd.sort_shift) begin
            r_j <= jm1;
        end

        if (i_cmd.sort_init) begin
            r_k <= CW'(1);
        end else if (i_cmd.sort_ins) begin
            r_k <= r_k + CW'(1);
        end

        if (i_cmd.scan_init0) begin
            r_top <= CW'(1);
        end else if (i_cmd.push) begin
            r_top <= topp1;
        end else if (i_cmd.pop) begin
            r_top <= r_top - CW'(1);
        end

        if (i_cmd.out_init) begin
            r_e <= '0;
        end else if (i_cmd.out_emit) begin
            r_e <= r_e + CW'(1);
        end

        if (i_cmd.geo_sort) begin
            r_s <= sr_rd;
        end
        if (i_cmd.geo_scan_new) begin
            r_c <= sr_rd;
        end

        if (i_cmd.scan_init0) begin
            r_t0 <= r_p;
        end else if (i_cmd.pop_fill) begin
            r_t0 <= sk_rd;
        end else if (i_cmd.push) begin
            r_t0 <= r_t1;
        end
        if (i_cmd.scan_init1) begin
            r_t1 <= sr_rd;
        end else if (i_cmd.pop) begin
            r_t1 <= r_t0;
        end else if (i_cmd.push) begin
            r_t1 <= r_c;
        end

        // Operands of the turn test: origin a, points b and c.
        if (i_cmd.geo_sort) begin
            r_ga <= r_p;
            r_gb <= r_q;
            r_gc <= sr_rd;
        end else if (i_cmd.geo_scan_new) begin
            r_ga <= r_t0;
            r_gb <= r_t1;
            r_gc <= sr_rd;
        end else if (i_cmd.geo_scan) begin
            r_ga <= r_t0;
            r_gb <= r_t1;
            r_gc <= r_c;
        end

        if (i_cmd.out_emit) begin
            r_res.hull_x         <= sk_rd.x;
            r_res.hull_y         <= sk_rd.y;
            r_res.final_vertex   <= (r_e == r_top - CW'(1));
            r_res.points_dropped <= r_ovf;
        end
    end

    // Turn test pipeline: differences, products, then cross product and distances.
    always_ff @(posedge i_clk) begin
        r_ux    <= chgs_pkg::DIFF_W'(r_gb.x) - chgs_pkg::DIFF_W'(r_ga.x);
        r_uy    <= chgs_pkg::DIFF_W'(r_gb.y) - chgs_pkg::DIFF_W'(r_ga.y);
        r_vx    <= chgs_pkg::DIFF_W'(r_gc.x) - chgs_pkg::DIFF_W'(r_ga.x);
        r_vy    <= chgs_pkg::DIFF_W'(r_gc.y) - chgs_pkg::DIFF_W'(r_ga.y);
        r_m1    <= chgs_pkg::PROD_W'(r_ux) * chgs_pkg::PROD_W'(r_vy);
        r_m2    <= chgs_pkg::PROD_W'(r_uy) * chgs_pkg::PROD_W'(r_vx);
        r_sa1   <= chgs_pkg::PROD_W'(r_ux) * chgs_pkg::PROD_W'(r_ux);
        r_sa2   <= chgs_pkg::PROD_W'(r_uy) * chgs_pkg::PROD_W'(r_uy);
        r_sb1   <= chgs_pkg::PROD_W'(r_vx) * chgs_pkg::PROD_W'(r_vx);
        r_sb2   <= chgs_pkg::PROD_W'(r_vy) * chgs_pkg::PROD_W'(r_vy);
        r_cross <= chgs_pkg::WIDE_W'(r_m1) - chgs_pkg::WIDE_W'(r_m2);
        r_da    <= chgs_pkg::WIDE_W'(r_sa1) + chgs_pkg::WIDE_W'(r_sa2);
        r_db    <= chgs_pkg::WIDE_W'(r_sb1) + chgs_pkg::WIDE_W'(r_sb2);
    end

    always_comb begin
        o_stat.i_last     = (r_i == r_n - CW'(1));
        o_stat.q_is_p     = (st_rd == r_p);
        o_stat.j_gt1      = (r_j > CW'(1));
        o_stat.cpos       = (r_cross > 0);
        o_stat.sort_first = (r_cross > 0) || ((r_cross == 0) && (r_da > r_db));
        o_stat.top_gt1    = (r_top > CW'(1));
        o_stat.i_eq_k     = (r_i == r_k);
        o_stat.k_eq1      = (r_k == CW'(1));
        o_stat.e_last     = (r_e == r_top - CW'(1));
    end

    assign o_result = r_res;
    assign o_valid  = r_vld;

    `CHGS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_n <= CW'(MAX_POINTS), "point count beyond capacity")
    `CHGS_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, r_vld, !r_vld, "results on adjacent cycles")
    `CHGS_ASSERT_NOW(a_pop_depth, i_clk, i_rst_n, i_cmd.pop, r_top > CW'(1), "pop below second entry")

endmodule

// ----- design/chgs_ctrl.sv -----
// Controller state machine of the convex hull block.
module chgs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_eos,
    input  chgs_pkg::t_stat i_stat,
    output logic            o_busy,
    output chgs_pkg::t_cmd  o_cmd
);

`include "convex_hull_graham_scan_defines.svh"

    typedef enum logic [25:0] {
        ST_IDLE      = 26'h0000001,
        ST_PIV_RD    = 26'h0000002,
        ST_PIV_CMP   = 26'h0000004,
        ST_SORT_INIT = 26'h0000008,
        ST_Q_RD      = 26'h0000010,
        ST_Q_LAT     = 26'h0000020,
        ST_J_CHK     = 26'h0000040,
        ST_S_LAT     = 26'h0000080,
        ST_G1        = 26'h0000100,
        ST_G2        = 26'h0000200,
        ST_G3        = 26'h0000400,
        ST_SORT_DEC  = 26'h0000800,
        ST_INS       = 26'h0001000,
        ST_SCAN_INIT = 26'h0002000,
        ST_SCAN_T1   = 26'h0004000,
        ST_C_RD      = 26'h0008000,
        ST_C_LAT     = 26'h0010000,
        ST_SG1       = 26'h0020000,
        ST_SG2       = 26'h0040000,
        ST_SG3       = 26'h0080000,
        ST_SCAN_DEC  = 26'h0100000,
        ST_POP_W     = 26'h0200000,
        ST_POP_G     = 26'h0400000,
        ST_OUT_INIT  = 26'h0800000,
        ST_OUT_RD    = 26'h1000000,
        ST_OUT_EM    = 26'h2000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_eos) begin
                        o_cmd.piv_init = 1'b1;
                        n_state = ST_PIV_RD;
                    end
                end
            end
            ST_PIV_RD: begin
                n_state = ST_PIV_CMP;
            end
            ST_PIV_CMP: begin
                o_cmd.piv_cmp = 1'b1;
                n_state = i_stat.i_last ? ST_SORT_INIT : ST_PIV_RD;
            end
            ST_SORT_INIT: begin
                o_cmd.sort_init = 1'b1;
                n_state = ST_Q_RD;
            end
            ST_Q_RD: begin
                n_state = ST_Q_LAT;
            end
            ST_Q_LAT: begin
                if (i_stat.q_is_p) begin
                    o_cmd.next_i = 1'b1;
                    n_state = i_stat.i_last ? ST_SCAN_INIT : ST_Q_RD;
                end else begin
                    o_cmd.q_latch = 1'b1;
                    n_state = ST_J_CHK;
                end
            end
            ST_J_CHK: begin
                if (i_stat.j_gt1) begin
                    o_cmd.srt_rd_j = 1'b1;
                    n_state = ST_S_LAT;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_S_LAT: begin
                o_cmd.geo_sort = 1'b1;
                n_state = ST_G1;
            end
            ST_G1: n_state = ST_G2;
            ST_G2: n_state = ST_G3;
            ST_G3: n_state = ST_SORT_DEC;
            ST_SORT_DEC: begin
                if (i_stat.sort_first) begin
                    o_cmd.sort_shift = 1'b1;
                    n_state = ST_J_CHK;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                o_cmd.sort_ins = 1'b1;
                n_state = i_stat.i_last ? ST_SCAN_INIT : ST_Q_RD;
            end
            ST_SCAN_INIT: begin
                o_cmd.scan_init0 = 1'b1;
                n_state = i_stat.k_eq1 ? ST_OUT_INIT : ST_SCAN_T1;
            end
            ST_SCAN_T1: begin
                o_cmd.scan_init1 = 1'b1;
                n_state = ST_C_RD;
            end
            ST_C_RD: begin
                n_state = ST_C_LAT;
            end
            ST_C_LAT: begin
                o_cmd.geo_scan_new = 1'b1;
                n_state = ST_SG1;
            end
            ST_SG1: n_state = ST_SG2;
            ST_SG2: n_state = ST_SG3;
            ST_SG3: n_state = ST_SCAN_DEC;
            ST_SCAN_DEC: begin
                if (i_stat.cpos || (!i_stat.top_gt1 && i_stat.i_eq_k)) begin
                    o_cmd.push = 1'b1;
                    n_state = i_stat.i_eq_k ? ST_OUT_INIT : ST_C_RD;
                end else if (i_stat.top_gt1) begin
                    o_cmd.pop = 1'b1;
                    n_state = ST_POP_W;
                end else begin
                    o_cmd.next_i = 1'b1;
                    n_state = ST_C_RD;
                end
            end
            ST_POP_W: begin
                o_cmd.pop_fill = 1'b1;
                n_state = ST_POP_G;
            end
            ST_POP_G: begin
                o_cmd.geo_scan = 1'b1;
                n_state = ST_SG1;
            end
            ST_OUT_INIT: begin
                o_cmd.out_init = 1'b1;
                n_state = ST_OUT_RD;
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_EM;
            end
            ST_OUT_EM: begin
                o_cmd.out_emit = 1'b1;
                if (i_stat.e_last) begin
                    o_cmd.clr_run = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    `CHGS_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, i_start && !o_busy && i_eos, o_busy, "run did not start")
    `CHGS_ASSERT_NOW(a_emit_read, i_clk, i_rst_n, r_state == ST_OUT_EM, $past(r_state) == ST_OUT_RD, "emit without read")
    `CHGS_ASSERT_NOW(a_load_idle, i_clk, i_rst_n, o_cmd.load, !o_busy, "load while busy")

endmodule

// ----- design/convex_hull_graham_scan.sv -----
// Points are loaded one per cycle while busy is low; after the last point the run performs the
// pivot search, the insertion sort by polar angle and the scan with its pops, sharing one turn
// test pipeline between sort and scan, then reads out the hull vertices. One request at a time;
// busy is high from the last point until the last vertex. Synchronous active-low reset empties
// the point set. Results appear on o_valid for one cycle each and cannot be stalled.
module convex_hull_graham_scan #(
    parameter int MAX_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  chgs_pkg::t_point_in i_point,
    output logic                o_valid,
    output chgs_pkg::t_hull_out o_result
);

    // The controller sequences loading, pivot search, insertion sort by polar angle,
    // the Graham scan and the read-out of the hull stack. All geometry sits in the datapath.
    chgs_pkg::t_cmd  cmd;
    chgs_pkg::t_stat stat;
    logic            ctrl_busy;

    chgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_eos   (i_point.end_of_set),
        .i_stat  (stat),
        .o_busy  (ctrl_busy),
        .o_cmd   (cmd)
    );

    // A request is taken only while the controller is idle, so the point store, the sorted
    // list and the hull stack are never shared between two sets.
    chgs_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (i_point),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

    assign busy = ctrl_busy;

endmodule

// ----- tb/convex_hull_graham_scan_tb.sv -----
// Testbench for the Graham scan convex hull block, checked against a behavioural predictor.
`timescale 1ns / 1ps

module convex_hull_graham_scan_tb;

    localparam int MAXP = 64;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    chgs_pkg::t_point_in i_point;
    logic                o_valid;
    chgs_pkg::t_hull_out o_result;

    convex_hull_graham_scan #(.MAX_POINTS(MAXP)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point(i_point), .o_valid(o_valid), .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Requests waiting to be driven, and hull vertices that the block still owes us.
    chgs_pkg::t_point_in pending_points[$];
    chgs_pkg::t_hull_out expected_vertices[$];
    int        fail_count = 0;
    bit        stimulus_done = 0;
    bit        idle_enable = 1;
    bit        hold_off = 0;

    // Predictor state: the points of the set being loaded and the overflow flag.
    longint    set_x[$];
    longint    set_y[$];
    bit        set_dropped = 0;

    function automatic longint turn(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    // True when a comes before b in angle order about the pivot; farther first on a tie.
    function automatic bit angle_first(longint px, longint py, longint ax, longint ay,
                                       longint bx, longint by);
        longint c;
        c = turn(px, py, ax, ay, bx, by);
        if (c != 0) return c > 0;
        return ((ax-px)*(ax-px) + (ay-py)*(ay-py)) > ((bx-px)*(bx-px) + (by-py)*(by-py));
    endfunction

    // Accepts one point into the predictor; on the last point of a set, queues the hull.
    task automatic predict_hull(input chgs_pkg::t_point_in pt);
        longint    sx[$], sy[$], hx[$], hy[$];
        longint    px, py, qx, qy;
        int        piv, j, top;
        bit        skip;
        chgs_pkg::t_hull_out v;
        if (set_x.size() < MAXP) begin
            set_x.push_back(longint'(pt.point_x));
            set_y.push_back(longint'(pt.point_y));
        end else begin
            set_dropped = 1;
        end
        if (!pt.end_of_set) return;
        piv = 0;
        for (int i = 1; i < set_x.size(); i++)
            if (set_y[i] < set_y[piv] || (set_y[i] == set_y[piv] && set_x[i] > set_x[piv]))
                piv = i;
        px = set_x[piv];
        py = set_y[piv];
        sx.push_back(px);
        sy.push_back(py);
        for (int i = 0; i < set_x.size(); i++) begin
            qx = set_x[i];
            qy = set_y[i];
            if (qx == px && qy == py) continue;
            sx.push_back(0);
            sy.push_back(0);
            j = sx.size() - 1;
            while (j > 1 && angle_first(px, py, qx, qy, sx[j-1], sy[j-1])) begin
                sx[j] = sx[j-1];
                sy[j] = sy[j-1];
                j--;
            end
            sx[j] = qx;
            sy[j] = qy;
        end
        hx.push_back(px);
        hy.push_back(py);
        if (sx.size() > 1) begin
            // The pivot is appended once more so the scan closes the loop.
            sx.push_back(px);
            sy.push_back(py);
            hx.push_back(sx[1]);
            hy.push_back(sy[1]);
            top = 1;
            for (int i = 2; i < sx.size(); i++) begin
                skip = 0;
                forever begin
                    if (turn(hx[top-1], hy[top-1], hx[top], hy[top], sx[i], sy[i]) > 0) break;
                    if (top > 1) begin
                        top--;
                    end else begin
                        skip = (i != sx.size() - 1);
                        break;
                    end
                end
                if (skip) continue;
                top++;
                while (hx.size() > top) begin
                    void'(hx.pop_back());
                    void'(hy.pop_back());
                end
                hx.push_back(sx[i]);
                hy.push_back(sy[i]);
            end
        end else begin
            top = 1;
        end
        for (int i = 0; i < top; i++) begin
            v.hull_x = hx[i][15:0];
            v.hull_y = hy[i][15:0];
            v.final_vertex = (i == top - 1);
            v.points_dropped = set_dropped;
            expected_vertices.push_back(v);
        end
        set_x.delete();
        set_y.delete();
        set_dropped = 0;
    endtask

    // Driver: start stays high across back-to-back requests, so it is never lowered and
    // raised in the same step. The prediction is made when the block accepts the request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_hull(i_point);
                void'(pending_points.pop_front());
            end
            if ((start && !busy) || !start) begin
                if (pending_points.size() > (start && !busy ? 1 : 0) - (start && !busy ? 1 : 0)
                    && pending_points.size() != 0 && !hold_off
                    && !(idle_enable && $urandom_range(99) < 18)) begin
                    start   <= 1'b1;
                    i_point <= pending_points[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed vertex is checked against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_vertices.size() == 0) begin
                $error("unexpected vertex x=%0d y=%0d", o_result.hull_x, o_result.hull_y);
                fail_count++;
            end else begin
                chgs_pkg::t_hull_out e;
                e = expected_vertices.pop_front();
                if (o_result.hull_x !== e.hull_x) begin
                    $error("hull_x expected %0d actual %0d", e.hull_x, o_result.hull_x);
                    fail_count++;
                end
                if (o_result.hull_y !== e.hull_y) begin
                    $error("hull_y expected %0d actual %0d", e.hull_y, o_result.hull_y);
                    fail_count++;
                end
                if (o_result.final_vertex !== e.final_vertex) begin
                    $error("final_vertex expected %0b actual %0b", e.final_vertex,
                           o_result.final_vertex);
                    fail_count++;
                end
                if (o_result.points_dropped !== e.points_dropped) begin
                    $error("points_dropped expected %0b actual %0b", e.points_dropped,
                           o_result.points_dropped);
                    fail_count++;
                end
            end
        end
    end

    function automatic chgs_pkg::t_point_in mk(int x, int y, bit last);
        chgs_pkg::t_point_in p;
        p.point_x = x[15:0];
        p.point_y = y[15:0];
        p.end_of_set = last;
        return p;
    endfunction

    // Queues a random set; the coordinate range is narrow at times so that repeats and
    // collinear runs turn up.
    task automatic add_random_set(int n);
        int span, x, y;
        span = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            case (span)
                0: begin x = $urandom_range(6) - 3; y = $urandom_range(6) - 3; end
                1: begin x = $urandom_range(2000) - 1000; y = x * 3 + $urandom_range(1); end
                default: begin x = $urandom_range(65535); y = $urandom_range(65535); end
            endcase
            if (x > 32767) x -= 65536;
            if (y > 32767) y -= 65536;
            pending_points.push_back(mk(x, y, i == n - 1));
        end
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_point = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets: a lone point, pivot copies, collinear points, the coordinate
        // extremes, and a square with repeated and interior points.
        pending_points.push_back(mk(5, 5, 1));
        pending_points.push_back(mk(7, 7, 0));
        pending_points.push_back(mk(7, 7, 1));
        pending_points.push_back(mk(0, 0, 0));
        pending_points.push_back(mk(2, 2, 0));
        pending_points.push_back(mk(1, 1, 1));
        pending_points.push_back(mk(-32768, -32768, 0));
        pending_points.push_back(mk(32767, -32768, 0));
        pending_points.push_back(mk(32767, 32767, 0));
        pending_points.push_back(mk(-32768, 32767, 0));
        pending_points.push_back(mk(0, 0, 1));
        pending_points.push_back(mk(0, 0, 0));
        pending_points.push_back(mk(4, 0, 0));
        pending_points.push_back(mk(4, 4, 0));
        pending_points.push_back(mk(4, 4, 0));
        pending_points.push_back(mk(0, 4, 0));
        pending_points.push_back(mk(2, 2, 0));
        pending_points.push_back(mk(2, 0, 1));

        // Pause until every vertex so far has arrived before going on.
        @(posedge i_clk);
        wait (pending_points.size() == 0);
        @(posedge i_clk);
        hold_off = 1;
        wait (expected_vertices.size() == 0 && !busy);
        hold_off = 0;

        // A set that overflows capacity, with the dropped points the last two.
        for (int i = 0; i < MAXP + 2; i++)
            pending_points.push_back(mk($urandom_range(200) - 100, $urandom_range(200) - 100,
                                        i == MAXP + 1));

        // Random sets, mostly small; the middle stretch runs without idling.
        for (int s = 0; s < 12; s++) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(MAXP) + 1 : $urandom_range(8) + 1;
            add_random_set(n);
            if (s == 3) begin
                wait (pending_points.size() == 0);
                idle_enable = 0;
            end
            if (s == 8) begin
                wait (pending_points.size() == 0);
                idle_enable = 1;
            end
        end
        wait (pending_points.size() == 0 && !start);
        wait (expected_vertices.size() == 0 && !busy);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && expected_vertices.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
